FILE: src/zcd_pkg.sv
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared types, constants and helpers for the back-EMF zero-cross detector.
// ----------------------------------------------------------------------------
package zcd_pkg;

    // sample and counter sizing
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int RUN_W       = 3;
    localparam int BLANK_W     = 4;
    localparam int SECTOR_W    = 3;
    localparam int PHASE_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 120;

    // reset values of the configuration registers
    localparam logic [SAMPLE_BITS-1:0] DEADBAND_RST  = SAMPLE_BITS'(8);
    localparam logic [RUN_W-1:0]       CONFIRM_RST   = RUN_W'(3);
    localparam logic [BLANK_W-1:0]     BLANK_RST     = BLANK_W'(2);
    localparam logic [SAMPLE_BITS-1:0] SAT_LOW_RST   = SAMPLE_BITS'(50);
    localparam logic [SAMPLE_BITS-1:0] SAT_HIGH_RST  = SAMPLE_BITS'(4045);

    // min/max tracker values while no unblanked scan has been seen
    localparam logic signed [DIFF_W-1:0] DIFF_NONE_LOW  = DIFF_W'((2 ** SAMPLE_BITS) - 1);
    localparam logic signed [DIFF_W-1:0] DIFF_NONE_HIGH = DIFF_W'(-(2 ** (SAMPLE_BITS - 1)));

    localparam logic [SECTOR_W-1:0] SECTOR_LAST = SECTOR_W'(5);

    // item kinds
    typedef enum logic [1:0] {
        OP_SCAN      = 2'd0,
        OP_COMMUTATE = 2'd1,
        OP_CLEAR     = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADBAND = 3'd0,
        REG_CONFIRM  = 3'd1,
        REG_BLANK    = 3'd2,
        REG_SAT_LOW  = 3'd3,
        REG_SAT_HIGH = 3'd4
    } reg_idx_t;

    // zero-cross event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } zc_event_t;

    // phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t hi;
        phase_t lo;
        phase_t fl;
    } phases_t;

    // per-filter control from the top level
    typedef struct packed {
        logic rearm;
        logic step;
    } flt_ctrl_t;

    // commutation table: driven-high, forced-low and floating phase
    function automatic phases_t sector_phases(input logic [SECTOR_W-1:0] sector);
        phases_t p;
        case (sector)
            3'd0:    p = '{hi: PH_A, lo: PH_B, fl: PH_C};
            3'd1:    p = '{hi: PH_A, lo: PH_C, fl: PH_B};
            3'd2:    p = '{hi: PH_B, lo: PH_C, fl: PH_A};
            3'd3:    p = '{hi: PH_B, lo: PH_A, fl: PH_C};
            3'd4:    p = '{hi: PH_C, lo: PH_A, fl: PH_B};
            3'd5:    p = '{hi: PH_C, lo: PH_B, fl: PH_A};
            default: p = '{hi: PH_A, lo: PH_B, fl: PH_C};
        endcase
        return p;
    endfunction

    // pick one phase sample
    function automatic logic [SAMPLE_BITS-1:0] phase_sel(
        input phase_t                  ph,
        input logic [SAMPLE_BITS-1:0]  a,
        input logic [SAMPLE_BITS-1:0]  b,
        input logic [SAMPLE_BITS-1:0]  c
    );
        logic [SAMPLE_BITS-1:0] v;
        case (ph)
            PH_A:    v = a;
            PH_B:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    // saturating increment
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

endpackage

FILE: src/zcd_filter.sv
// ----------------------------------------------------------------------------
// zcd_filter
// Deadband and confirm-count filter with an armed direction bit. The armed
// bit flips on every confirmation; the direction sought follows the armed
// bit for the rising filter and its inverse for the falling filter.
// ----------------------------------------------------------------------------
module zcd_filter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  zcd_pkg::flt_ctrl_t                     ctrl_i,
    input  logic                                   up_when_armed_i,
    input  logic [zcd_pkg::SAMPLE_BITS-1:0]        deadband_i,
    input  logic [zcd_pkg::RUN_W-1:0]              need_i,
    input  logic signed [zcd_pkg::DIFF_W-1:0]      diff_i,
    output logic                                   confirm_o,
    output logic                                   armed_o
);
    import zcd_pkg::*;

    logic [RUN_W-1:0]         run_reg, run_next;
    logic                     armed_reg, armed_next;
    logic signed [DIFF_W:0]   d_ext;
    logic signed [DIFF_W:0]   db_pos;
    logic signed [DIFF_W:0]   db_neg;
    logic                     look_up;
    logic                     qualify;
    logic [RUN_W-1:0]         run_inc;

    // qualify the scan against the deadband in the sought direction
    always_comb begin
        d_ext   = {diff_i[DIFF_W-1], diff_i};
        db_pos  = {2'b00, deadband_i};
        db_neg  = -db_pos;
        look_up = (armed_reg == up_when_armed_i);
        qualify = look_up ? (d_ext >= db_pos) : (d_ext <= db_neg);
        if (!qualify) begin
            run_inc = '0;
        end else if (run_reg < need_i) begin
            run_inc = run_reg + RUN_W'(1);
        end else begin
            run_inc = run_reg;
        end
        confirm_o = (run_inc >= need_i);
    end

    // next state
    always_comb begin
        run_next   = run_reg;
        armed_next = armed_reg;
        if (ctrl_i.rearm) begin
            run_next   = '0;
            armed_next = 1'b1;
        end else if (ctrl_i.step) begin
            run_next = confirm_o ? '0 : run_inc;
            if (confirm_o) begin
                armed_next = ~armed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            armed_reg <= 1'b1;
        end else begin
            run_reg   <= run_next;
            armed_reg <= armed_next;
        end
    end

    assign armed_o = armed_reg;

endmodule

FILE: src/bemf_zero_cross_detector.sv
// ----------------------------------------------------------------------------
// bemf_zero_cross_detector
// Six-step sensorless back-EMF zero-cross detector with blanking, saturation
// counts, min/max diff tracking and a one-event-per-sector lock.
//
//   channel   dir  accepted when              carries
//   s_*       in   s_tvalid & s_tready        one scan, commutate or clear
//   m_*       out  m_tvalid & m_tready        one result per input transfer
//   cfg_*     in   cfg_wr_en                  register write, no read-back
//
// One transfer per cycle sustained while m_tready is high; each item's
// result is registered in the cycle after its input transfer. State and the
// result register load at the same edge: the next item sees updated state.
// s_tready is low only while a result waits and m_tready is low.
// aresetn is synchronous; all state but m_tdata returns to its reset values.
// ----------------------------------------------------------------------------
module bemf_zero_cross_detector (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [zcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [zcd_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // adc_a[11:0], adc_b[23:12], adc_c[35:24], sense_enable[36], zero pad
    input  logic [zcd_pkg::S_TDATA_W-1:0]         s_tdata,
    // op[1:0]
    input  logic [zcd_pkg::S_TUSER_W-1:0]         s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // zc_event[1:0], sector[4:2], high_phase[6:5], low_phase[8:7],
    // float_phase[10:9], diff[23:11], diff_low[36:24], diff_high[49:37],
    // rising_total[65:50], falling_total[81:66], sat_low_total[97:82],
    // sat_high_total[113:98], zero pad
    output logic [zcd_pkg::M_TDATA_W-1:0]         m_tdata
);
    import zcd_pkg::*;

    // configuration registers
    logic [SAMPLE_BITS-1:0]     deadband_reg;
    logic [RUN_W-1:0]           confirm_reg;
    logic [BLANK_W-1:0]         blank_scans_reg;
    logic [SAMPLE_BITS-1:0]     sat_low_reg;
    logic [SAMPLE_BITS-1:0]     sat_high_reg;

    // detector state
    logic [SECTOR_W-1:0]        sector_reg, sector_next;
    logic [BLANK_W-1:0]         blank_left_reg, blank_left_next;
    logic                       lock_reg, lock_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [DIFF_W-1:0]   diff_low_reg, diff_low_next;
    logic signed [DIFF_W-1:0]   diff_high_reg, diff_high_next;
    logic [COUNT_BITS-1:0]      rising_reg, rising_next;
    logic [COUNT_BITS-1:0]      falling_reg, falling_next;
    logic [COUNT_BITS-1:0]      sat_low_cnt_reg, sat_low_cnt_next;
    logic [COUNT_BITS-1:0]      sat_high_cnt_reg, sat_high_cnt_next;

    // result register
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // datapath
    logic                       accept;
    op_t                        op;
    logic [SAMPLE_BITS-1:0]     adc_a, adc_b, adc_c;
    logic                       sense_enable;
    phases_t                    cur_ph, new_ph;
    logic [SAMPLE_BITS-1:0]     fl_smp, hi_smp;
    logic signed [DIFF_W-1:0]   d;
    logic                       is_scan, unblanked, filt_go;
    logic [RUN_W-1:0]           need;
    flt_ctrl_t                  rise_ctrl, fall_ctrl;
    logic                       rise_confirm, rise_armed;
    logic                       fall_confirm, fall_armed;
    logic                       rise_ev, fall_ev;
    zc_event_t                  ev;

    // handshake
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // unpack the input transfer
    assign op           = op_t'(s_tuser);
    assign adc_a        = s_tdata[11:0];
    assign adc_b        = s_tdata[23:12];
    assign adc_c        = s_tdata[35:24];
    assign sense_enable = s_tdata[36];

    // floating minus half the high-side sample
    always_comb begin
        cur_ph = sector_phases(sector_reg);
        fl_smp = phase_sel(cur_ph.fl, adc_a, adc_b, adc_c);
        hi_smp = phase_sel(cur_ph.hi, adc_a, adc_b, adc_c);
        d      = signed'({1'b0, fl_smp}) - signed'({2'b00, hi_smp[SAMPLE_BITS-1:1]});
    end

    // scan qualification and filter control
    always_comb begin
        is_scan   = (op == OP_SCAN) && sense_enable;
        unblanked = is_scan && (blank_left_reg == '0);
        filt_go   = unblanked && !lock_reg;
        need      = (confirm_reg == '0) ? RUN_W'(1) : confirm_reg;

        rise_ctrl.rearm = accept && (op == OP_COMMUTATE);
        rise_ctrl.step  = accept && filt_go;
        rise_ev         = filt_go && rise_confirm && rise_armed;

        fall_ctrl.rearm = rise_ctrl.rearm;
        fall_ctrl.step  = accept && filt_go && !rise_ev;
        fall_ev         = filt_go && !rise_ev && fall_confirm && fall_armed;
    end

    zcd_filter u_rise_filter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl_i          (rise_ctrl),
        .up_when_armed_i (1'b1),
        .deadband_i      (deadband_reg),
        .need_i          (need),
        .diff_i          (d),
        .confirm_o       (rise_confirm),
        .armed_o         (rise_armed)
    );

    zcd_filter u_fall_filter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl_i          (fall_ctrl),
        .up_when_armed_i (1'b0),
        .deadband_i      (deadband_reg),
        .need_i          (need),
        .diff_i          (d),
        .confirm_o       (fall_confirm),
        .armed_o         (fall_armed)
    );

    // next state per item kind
    always_comb begin
        sector_next       = sector_reg;
        blank_left_next   = blank_left_reg;
        lock_next         = lock_reg;
        diff_next         = diff_reg;
        diff_low_next     = diff_low_reg;
        diff_high_next    = diff_high_reg;
        rising_next       = rising_reg;
        falling_next      = falling_reg;
        sat_low_cnt_next  = sat_low_cnt_reg;
        sat_high_cnt_next = sat_high_cnt_reg;
        ev                = EV_NONE;
        case (op)
            OP_COMMUTATE: begin
                sector_next     = (sector_reg == SECTOR_LAST) ? '0
                                                              : sector_reg + SECTOR_W'(1);
                lock_next       = 1'b0;
                blank_left_next = blank_scans_reg;
            end
            OP_CLEAR: begin
                diff_low_next     = DIFF_NONE_LOW;
                diff_high_next    = DIFF_NONE_HIGH;
                rising_next       = '0;
                falling_next      = '0;
                sat_low_cnt_next  = '0;
                sat_high_cnt_next = '0;
            end
            OP_SCAN: begin
                if (is_scan) begin
                    diff_next = d;
                    if (!unblanked) begin
                        blank_left_next = blank_left_reg - BLANK_W'(1);
                    end else begin
                        if (fl_smp <= sat_low_reg) begin
                            sat_low_cnt_next = sat_inc(sat_low_cnt_reg);
                        end
                        if (fl_smp >= sat_high_reg) begin
                            sat_high_cnt_next = sat_inc(sat_high_cnt_reg);
                        end
                        if (d < diff_low_reg) begin
                            diff_low_next = d;
                        end
                        if (d > diff_high_reg) begin
                            diff_high_next = d;
                        end
                        if (rise_ev) begin
                            lock_next   = 1'b1;
                            rising_next = sat_inc(rising_reg);
                            ev          = EV_RISE;
                        end else if (fall_ev) begin
                            lock_next    = 1'b1;
                            falling_next = sat_inc(falling_reg);
                            ev           = EV_FALL;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // pack the result from the post-item state
    always_comb begin
        new_ph       = sector_phases(sector_next);
        m_tdata_next = {
            6'b0,
            sat_high_cnt_next,
            sat_low_cnt_next,
            falling_next,
            rising_next,
            diff_high_next,
            diff_low_next,
            diff_next,
            new_ph.fl,
            new_ph.lo,
            new_ph.hi,
            sector_next,
            ev
        };
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg    <= DEADBAND_RST;
            confirm_reg     <= CONFIRM_RST;
            blank_scans_reg <= BLANK_RST;
            sat_low_reg     <= SAT_LOW_RST;
            sat_high_reg    <= SAT_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEADBAND: deadband_reg    <= cfg_wr_data[SAMPLE_BITS-1:0];
                REG_CONFIRM:  confirm_reg     <= cfg_wr_data[RUN_W-1:0];
                REG_BLANK:    blank_scans_reg <= cfg_wr_data[BLANK_W-1:0];
                REG_SAT_LOW:  sat_low_reg     <= cfg_wr_data[SAMPLE_BITS-1:0];
                REG_SAT_HIGH: sat_high_reg    <= cfg_wr_data[SAMPLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // detector state update on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg       <= '0;
            blank_left_reg   <= BLANK_RST;
            lock_reg         <= 1'b0;
            diff_reg         <= '0;
            diff_low_reg     <= DIFF_NONE_LOW;
            diff_high_reg    <= DIFF_NONE_HIGH;
            rising_reg       <= '0;
            falling_reg      <= '0;
            sat_low_cnt_reg  <= '0;
            sat_high_cnt_reg <= '0;
        end else if (accept) begin
            sector_reg       <= sector_next;
            blank_left_reg   <= blank_left_next;
            lock_reg         <= lock_next;
            diff_reg         <= diff_next;
            diff_low_reg     <= diff_low_next;
            diff_high_reg    <= diff_high_next;
            rising_reg       <= rising_next;
            falling_reg      <= falling_next;
            sat_low_cnt_reg  <= sat_low_cnt_next;
            sat_high_cnt_reg <= sat_high_cnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
